// File: design/particle_vortex_velocity_update_macros.svh
// Assertion helpers for the vortex velocity update block.
// They expect signals named clk and arst_n in the scope where they are used.
`ifndef PARTICLE_VORTEX_VELOCITY_UPDATE_MACROS_SVH
`define PARTICLE_VORTEX_VELOCITY_UPDATE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PVVU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PVVU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/pvvu_pkg.sv
package pvvu_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 64;
	localparam int MAG_LIM_LOG2 = 47;

	typedef enum logic [2:0] {
		REG_OFF_X = 3'd0,
		REG_OFF_Y = 3'd1,
		REG_INNER = 3'd2,
		REG_OUTER = 3'd3,
		REG_STRENGTH = 3'd4,
		REG_MAX_SPEED = 3'd5,
		REG_COS = 3'd6,
		REG_SIN = 3'd7
	} reg_idx_t;

	// One step of the digit-by-digit square root: two radicand bits in, one root bit out.
	typedef struct packed {
		logic [63:0] x;
		logic [34:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// One step of restoring division: quotient bits shift in where numerator bits leave.
	typedef struct packed {
		logic [63:0] num;
		logic [31:0] rem;
		logic [31:0] den;
	} div_t;

	function automatic sqrt_t sqrt_step(sqrt_t a);
		sqrt_t r;
		logic [34:0] rem2;
		logic [34:0] trial;
		rem2 = {a.rem[32:0], a.x[63:62]};
		trial = {1'b0, a.root, 2'b01};
		r.x = {a.x[61:0], 2'b00};
		if (rem2 >= trial) begin
			r.rem = rem2 - trial;
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem = rem2;
			r.root = {a.root[30:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_t div_step(div_t a);
		div_t r;
		logic [32:0] rem2;
		logic [32:0] diff;
		logic ge;
		rem2 = {a.rem, a.num[63]};
		diff = rem2 - {1'b0, a.den};
		ge = (rem2 >= {1'b0, a.den});
		r.rem = ge ? diff[31:0] : rem2[31:0];
		r.num = {a.num[62:0], ge};
		r.den = a.den;
		return r;
	endfunction

endpackage

// File: design/pvvu_in_if.sv
interface pvvu_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] trigger_x;
	logic signed [31:0] trigger_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic [15:0] time_step;
	logic apply;
	logic last_in;

	modport source (output valid, pos_x, pos_y, trigger_x, trigger_y, vel_x, vel_y,
		time_step, apply, last_in, input ready);
	modport sink (input valid, pos_x, pos_y, trigger_x, trigger_y, vel_x, vel_y,
		time_step, apply, last_in, output ready);
endinterface

// File: design/pvvu_out_if.sv
interface pvvu_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] new_vel_x;
	logic signed [31:0] new_vel_y;
	logic in_band;
	logic speed_clamped;
	logic last_out;

	modport source (output valid, new_vel_x, new_vel_y, in_band, speed_clamped, last_out,
		input ready);
	modport sink (input valid, new_vel_x, new_vel_y, in_band, speed_clamped, last_out,
		output ready);
endinterface

// File: design/pvvu_cfg_if.sv
interface pvvu_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/pvvu_div.sv
// Pipelined unsigned divider, one quotient bit per stage.
module pvvu_div (
	input logic clk,
	input logic en,
	input logic [63:0] num,
	input logic [31:0] den,
	output logic [63:0] quo
);

	pvvu_pkg::div_t stg_q [pvvu_pkg::DIV_STEPS];
	pvvu_pkg::div_t init;

	always_comb begin
		init.num = num;
		init.rem = '0;
		init.den = den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_q[0] <= pvvu_pkg::div_step(init);
			for (int k = 1; k < pvvu_pkg::DIV_STEPS; k++) begin
				stg_q[k] <= pvvu_pkg::div_step(stg_q[k-1]);
			end
		end
	end

	assign quo = stg_q[pvvu_pkg::DIV_STEPS-1].num;

endmodule

// File: design/particle_vortex_velocity_update.sv
// Vortex velocity update, one particle per beat.
// The particle channel carries position, trigger position, velocity, time step, an apply
// bit and a batch marker; the result channel returns the updated velocity, the in_band and
// speed_clamped flags and the batch marker, one result beat per particle, in order.
// The cfg channel writes the eight vortex registers; it is always ready and is meant to be
// used only while no particle is in flight.
// Throughput is one particle per cycle while the result channel does not stall. An
// accepted particle beat reaches its result beat through four setup stages, a 32-stage
// square root for the distance, a 64-stage divider for direction and force, five stages
// of force and speed math, a second 32-stage square root for the speed, one multiply
// stage, a second 64-stage divider for the clamp, and the output register.
// The whole pipe advances together. When the receiver holds ready low while a result
// beat waits, every stage holds and the particle channel drops ready, so nothing is lost
// or repeated; bubbles inside the pipe hold in place along with the valid beats.
// Reset clears all valid bits and loads the registers with their defaults: zero offsets,
// radii and strength, the largest speed limit and a rotation of zero degrees.
module particle_vortex_velocity_update (
	input logic clk,
	input logic arst_n,
	pvvu_in_if.sink particle,
	pvvu_out_if.source result,
	pvvu_cfg_if.sink cfg
);

	localparam int SQN = pvvu_pkg::SQRT_STEPS;
	localparam int DVN = pvvu_pkg::DIV_STEPS;

	// Configuration registers.
	logic signed [31:0] off_x_q;
	logic signed [31:0] off_y_q;
	logic [30:0] inner_q;
	logic [30:0] outer_q;
	logic signed [31:0] strength_q;
	logic [30:0] max_speed_q;
	logic signed [15:0] cos_q;
	logic signed [15:0] sin_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			inner_q <= '0;
			outer_q <= '0;
			strength_q <= '0;
			max_speed_q <= '1;
			cos_q <= 16'sd16384;
			sin_q <= '0;
		end else if (cfg.valid) begin
			unique case (pvvu_pkg::reg_idx_t'(cfg.index))
				pvvu_pkg::REG_OFF_X: off_x_q <= cfg.data;
				pvvu_pkg::REG_OFF_Y: off_y_q <= cfg.data;
				pvvu_pkg::REG_INNER: inner_q <= cfg.data[30:0];
				pvvu_pkg::REG_OUTER: outer_q <= cfg.data[30:0];
				pvvu_pkg::REG_STRENGTH: strength_q <= cfg.data;
				pvvu_pkg::REG_MAX_SPEED: max_speed_q <= cfg.data[30:0];
				pvvu_pkg::REG_COS: cos_q <= cfg.data[15:0];
				pvvu_pkg::REG_SIN: sin_q <= cfg.data[15:0];
			endcase
		end
	end

	// Global advance: the pipe moves whenever the output register can take a beat.
	logic adv;
	logic out_vld_q;
	assign adv = !out_vld_q || result.ready;
	assign particle.ready = adv;

	// Side data carried along the long stages.
	typedef struct packed {
		logic signed [48:0] nx;
		logic signed [48:0] ny;
		logic signed [63:0] fo;
		logic band;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic last;
	} side_a_t;

	typedef struct packed {
		logic sx;
		logic sy;
		logic sm;
		logic band;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic last;
	} side_b_t;

	typedef struct packed {
		logic signed [31:0] nvx;
		logic signed [31:0] nvy;
		logic clamp;
		logic band;
		logic last;
	} side_c_t;

	// Stage 1: offset from the vortex center.
	logic signed [33:0] dx_s1, dy_s1;
	logic signed [31:0] vx_s1, vy_s1;
	logic [15:0] dt_s1;
	logic apply_s1, last_s1;

	// Stage 2: magnitudes squared and the raw force product.
	logic [61:0] adx2_s2, ady2_s2, in2_s2, out2_s2;
	logic near_s2, apply_s2, last_s2;
	logic signed [31:0] dx_s2, dy_s2, vx_s2, vy_s2;
	logic signed [48:0] fp_s2;

	// Stage 3: distance squared, band test, rotation products, scaled strength.
	logic [62:0] d2_s3;
	logic band_s3, last_s3;
	logic signed [47:0] pdxc_s3, pdys_s3, pdxs_s3, pdyc_s3;
	logic signed [31:0] f_s3, vx_s3, vy_s3;

	// Stage 4: rotated direction numerators and the force numerator.
	logic [62:0] d2_s4;
	side_a_t sa_s4;

	// Distance square root, stages 5 to 36.
	pvvu_pkg::sqrt_t sq1_s5 [SQN];
	side_a_t sd1_s5 [SQN];

	// First divider, stages 37 to 100.
	side_b_t sd2_s37 [DVN];

	// Stages after the first divider.
	logic signed [17:0] rx_s101, ry_s101;
	logic signed [48:0] m_s101;
	side_b_t sb_s101;
	logic signed [66:0] px_s102, py_s102;
	side_b_t sb_s102;
	logic signed [31:0] nvx_s103, nvy_s103;
	logic band_s103, last_s103;
	logic [63:0] ax2_s104, ay2_s104;
	logic [61:0] ms2_s104;
	logic signed [31:0] nvx_s104, nvy_s104;
	logic band_s104, last_s104;
	logic [63:0] v2_s105;
	side_c_t sc_s105;

	// Speed square root, stages 106 to 137.
	pvvu_pkg::sqrt_t sq2_s106 [SQN];
	side_c_t sd3_s106 [SQN];

	// Clamp multiply, stage 138, then the second divider, stages 139 to 202.
	logic signed [63:0] cpx_s138, cpy_s138;
	logic [31:0] s_s138;
	side_c_t sc_s138;
	side_c_t sd4_s139 [DVN];

	// Output register, stage 203.
	logic signed [31:0] nvx_o_q, nvy_o_q;
	logic band_o_q, clamp_o_q, last_o_q;

	// Valid bits for every stage.
	logic v_s1, v_s2, v_s3, v_s4;
	logic [SQN-1:0] v_sq1;
	logic [DVN-1:0] v_dv1;
	logic v_s101, v_s102, v_s103, v_s104, v_s105;
	logic [SQN-1:0] v_sq2;
	logic v_s138;
	logic [DVN-1:0] v_dv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_sq1 <= '0;
			v_dv1 <= '0;
			v_s101 <= 1'b0;
			v_s102 <= 1'b0;
			v_s103 <= 1'b0;
			v_s104 <= 1'b0;
			v_s105 <= 1'b0;
			v_sq2 <= '0;
			v_s138 <= 1'b0;
			v_dv2 <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= particle.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sq1 <= {v_sq1[SQN-2:0], v_s4};
			v_dv1 <= {v_dv1[DVN-2:0], v_sq1[SQN-1]};
			v_s101 <= v_dv1[DVN-1];
			v_s102 <= v_s101;
			v_s103 <= v_s102;
			v_s104 <= v_s103;
			v_s105 <= v_s104;
			v_sq2 <= {v_sq2[SQN-2:0], v_s105};
			v_s138 <= v_sq2[SQN-1];
			v_dv2 <= {v_dv2[DVN-2:0], v_s138};
			out_vld_q <= v_dv2[DVN-1];
		end
	end

	// Combinational helpers between stages.
	logic signed [33:0] adx, ady;
	logic [62:0] d2_c;
	logic signed [48:0] fr_c;
	pvvu_pkg::sqrt_t sq1_init, sq2_init;
	logic signed [48:0] nx_e, ny_e;
	logic signed [63:0] fo_e;
	logic [63:0] num_rx, num_ry, num_m, q_rx, q_ry, q_m;
	logic [31:0] d_root, s_root;
	logic signed [17:0] rx_mag, ry_mag;
	logic [63:0] m_mag;
	logic signed [66:0] tqx, tqy;
	logic signed [55:0] sumx, sumy;
	logic signed [31:0] satx, saty;
	logic [31:0] anx, any;
	logic [63:0] num_cx, num_cy, q_cx, q_cy;
	side_c_t sc_end;
	side_a_t sa_end;
	side_b_t sb_end;

	always_comb begin
		adx = dx_s1[33] ? -dx_s1 : dx_s1;
		ady = dy_s1[33] ? -dy_s1 : dy_s1;
		d2_c = {1'b0, adx2_s2} + {1'b0, ady2_s2};
		// Truncate the strength product toward zero before dropping the time step scale.
		fr_c = fp_s2 + (fp_s2[48] ? 49'sd65535 : 49'sd0);

		sq1_init.x = {1'b0, d2_s4};
		sq1_init.rem = '0;
		sq1_init.root = '0;
		sq2_init.x = v2_s105;
		sq2_init.rem = '0;
		sq2_init.root = '0;

		sa_end = sd1_s5[SQN-1];
		d_root = sq1_s5[SQN-1].root;
		nx_e = sa_end.nx;
		ny_e = sa_end.ny;
		fo_e = sa_end.fo;
		num_rx = 64'(nx_e[48] ? -nx_e : nx_e);
		num_ry = 64'(ny_e[48] ? -ny_e : ny_e);
		num_m = fo_e[63] ? -fo_e : fo_e;

		// A direction component never exceeds 2^16 in magnitude, so 17 bits hold it.
		sb_end = sd2_s37[DVN-1];
		rx_mag = {1'b0, q_rx[16:0]};
		ry_mag = {1'b0, q_ry[16:0]};
		m_mag = (q_m > (64'd1 << pvvu_pkg::MAG_LIM_LOG2)) ?
			(64'd1 << pvvu_pkg::MAG_LIM_LOG2) : q_m;

		// Force contribution, Q2.14 scale removed with truncation toward zero.
		tqx = (px_s102 + (px_s102[66] ? 67'sd16383 : 67'sd0)) >>> 14;
		tqy = (py_s102 + (py_s102[66] ? 67'sd16383 : 67'sd0)) >>> 14;
		sumx = 56'(sb_s102.vx) + tqx[55:0];
		sumy = 56'(sb_s102.vy) + tqy[55:0];
		if (sumx > 56'sd2147483647) begin
			satx = 32'sh7FFF_FFFF;
		end else if (sumx < -56'sd2147483648) begin
			satx = 32'sh8000_0000;
		end else begin
			satx = sumx[31:0];
		end
		if (sumy > 56'sd2147483647) begin
			saty = 32'sh7FFF_FFFF;
		end else if (sumy < -56'sd2147483648) begin
			saty = 32'sh8000_0000;
		end else begin
			saty = sumy[31:0];
		end

		anx = nvx_s103[31] ? 32'(-33'(nvx_s103)) : nvx_s103;
		any = nvy_s103[31] ? 32'(-33'(nvy_s103)) : nvy_s103;

		s_root = sq2_s106[SQN-1].root;
		num_cx = cpx_s138[63] ? -cpx_s138 : cpx_s138;
		num_cy = cpy_s138[63] ? -cpy_s138 : cpy_s138;
		sc_end = sd4_s139[DVN-1];
	end

	pvvu_div u_div_rx (.clk(clk), .en(adv), .num(num_rx), .den(d_root), .quo(q_rx));
	pvvu_div u_div_ry (.clk(clk), .en(adv), .num(num_ry), .den(d_root), .quo(q_ry));
	pvvu_div u_div_m (.clk(clk), .en(adv), .num(num_m), .den(d_root), .quo(q_m));
	pvvu_div u_div_cx (.clk(clk), .en(adv), .num(num_cx), .den(s_s138), .quo(q_cx));
	pvvu_div u_div_cy (.clk(clk), .en(adv), .num(num_cy), .den(s_s138), .quo(q_cy));

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= 34'(particle.pos_x) - 34'(particle.trigger_x) - 34'(off_x_q);
			dy_s1 <= 34'(particle.pos_y) - 34'(particle.trigger_y) - 34'(off_y_q);
			vx_s1 <= particle.vel_x;
			vy_s1 <= particle.vel_y;
			dt_s1 <= particle.time_step;
			apply_s1 <= particle.apply;
			last_s1 <= particle.last_in;

			adx2_s2 <= 62'(adx[30:0]) * 62'(adx[30:0]);
			ady2_s2 <= 62'(ady[30:0]) * 62'(ady[30:0]);
			in2_s2 <= 62'(inner_q) * 62'(inner_q);
			out2_s2 <= 62'(outer_q) * 62'(outer_q);
			near_s2 <= (adx <= $signed({3'b000, outer_q})) && (ady <= $signed({3'b000, outer_q}));
			apply_s2 <= apply_s1;
			last_s2 <= last_s1;
			dx_s2 <= dx_s1[31:0];
			dy_s2 <= dy_s1[31:0];
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			fp_s2 <= 49'(strength_q) * 49'($signed({1'b0, dt_s1}));

			d2_s3 <= d2_c;
			band_s3 <= apply_s2 && near_s2 && (d2_c != '0) && (d2_c >= {1'b0, in2_s2}) &&
				(d2_c <= {1'b0, out2_s2});
			last_s3 <= last_s2;
			pdxc_s3 <= 48'(dx_s2) * 48'(cos_q);
			pdys_s3 <= 48'(dy_s2) * 48'(sin_q);
			pdxs_s3 <= 48'(dx_s2) * 48'(sin_q);
			pdyc_s3 <= 48'(dy_s2) * 48'(cos_q);
			f_s3 <= fr_c[47:16];
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;

			d2_s4 <= d2_s3;
			sa_s4.nx <= 49'(pdys_s3) - 49'(pdxc_s3);
			sa_s4.ny <= -49'(pdxs_s3) - 49'(pdyc_s3);
			sa_s4.fo <= 64'(f_s3) * 64'($signed({1'b0, outer_q}));
			sa_s4.band <= band_s3;
			sa_s4.vx <= vx_s3;
			sa_s4.vy <= vy_s3;
			sa_s4.last <= last_s3;

			sq1_s5[0] <= pvvu_pkg::sqrt_step(sq1_init);
			sd1_s5[0] <= sa_s4;
			for (int k = 1; k < SQN; k++) begin
				sq1_s5[k] <= pvvu_pkg::sqrt_step(sq1_s5[k-1]);
				sd1_s5[k] <= sd1_s5[k-1];
			end

			sd2_s37[0].sx <= nx_e[48];
			sd2_s37[0].sy <= ny_e[48];
			sd2_s37[0].sm <= fo_e[63];
			sd2_s37[0].band <= sa_end.band;
			sd2_s37[0].vx <= sa_end.vx;
			sd2_s37[0].vy <= sa_end.vy;
			sd2_s37[0].last <= sa_end.last;
			for (int k = 1; k < DVN; k++) begin
				sd2_s37[k] <= sd2_s37[k-1];
			end

			rx_s101 <= sb_end.sx ? -rx_mag : rx_mag;
			ry_s101 <= sb_end.sy ? -ry_mag : ry_mag;
			m_s101 <= sb_end.sm ? -$signed(m_mag[48:0]) : $signed(m_mag[48:0]);
			sb_s101 <= sb_end;

			px_s102 <= 67'(m_s101) * 67'(rx_s101);
			py_s102 <= 67'(m_s101) * 67'(ry_s101);
			sb_s102 <= sb_s101;

			nvx_s103 <= sb_s102.band ? satx : sb_s102.vx;
			nvy_s103 <= sb_s102.band ? saty : sb_s102.vy;
			band_s103 <= sb_s102.band;
			last_s103 <= sb_s102.last;

			ax2_s104 <= 64'(anx) * 64'(anx);
			ay2_s104 <= 64'(any) * 64'(any);
			ms2_s104 <= 62'(max_speed_q) * 62'(max_speed_q);
			nvx_s104 <= nvx_s103;
			nvy_s104 <= nvy_s103;
			band_s104 <= band_s103;
			last_s104 <= last_s103;

			v2_s105 <= ax2_s104 + ay2_s104;
			sc_s105.nvx <= nvx_s104;
			sc_s105.nvy <= nvy_s104;
			sc_s105.clamp <= band_s104 && ((ax2_s104 + ay2_s104) > {2'b00, ms2_s104});
			sc_s105.band <= band_s104;
			sc_s105.last <= last_s104;

			sq2_s106[0] <= pvvu_pkg::sqrt_step(sq2_init);
			sd3_s106[0] <= sc_s105;
			for (int k = 1; k < SQN; k++) begin
				sq2_s106[k] <= pvvu_pkg::sqrt_step(sq2_s106[k-1]);
				sd3_s106[k] <= sd3_s106[k-1];
			end

			cpx_s138 <= 64'(sd3_s106[SQN-1].nvx) * 64'($signed({1'b0, max_speed_q}));
			cpy_s138 <= 64'(sd3_s106[SQN-1].nvy) * 64'($signed({1'b0, max_speed_q}));
			s_s138 <= s_root;
			sc_s138 <= sd3_s106[SQN-1];

			sd4_s139[0] <= sc_s138;
			for (int k = 1; k < DVN; k++) begin
				sd4_s139[k] <= sd4_s139[k-1];
			end

			// The scaled component never exceeds max_speed, so 32 bits hold it.
			if (sc_end.clamp) begin
				nvx_o_q <= sc_end.nvx[31] ? -$signed(q_cx[31:0]) : $signed(q_cx[31:0]);
				nvy_o_q <= sc_end.nvy[31] ? -$signed(q_cy[31:0]) : $signed(q_cy[31:0]);
			end else begin
				nvx_o_q <= sc_end.nvx;
				nvy_o_q <= sc_end.nvy;
			end
			band_o_q <= sc_end.band;
			clamp_o_q <= sc_end.clamp;
			last_o_q <= sc_end.last;
		end
	end

	assign result.valid = out_vld_q;
	assign result.new_vel_x = nvx_o_q;
	assign result.new_vel_y = nvy_o_q;
	assign result.in_band = band_o_q;
	assign result.speed_clamped = clamp_o_q;
	assign result.last_out = last_o_q;

endmodule

// File: design/pvvu_checker.sv
`include "particle_vortex_velocity_update_macros.svh"

module pvvu_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic in_band,
	input logic speed_clamped,
	input logic [31:0] new_vel_x,
	input logic cfg_ready
);

	// The input side may only stall while a result beat is held back.
	`PVVU_ASSERT_NOW(a_ready_follows_out, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow the output stall")

	// A held result beat stays put.
	`PVVU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_vel_x), "stalled result beat changed")

	// Only particles that took the force can be clamped.
	`PVVU_ASSERT_NOW(a_clamp_needs_band, out_valid && !in_band, !speed_clamped, "clamp flagged outside the band")

	// Configuration writes are never refused.
	`PVVU_ASSERT_NOW(a_cfg_ready, in_valid || !in_valid, cfg_ready, "configuration port not ready")

endmodule

bind particle_vortex_velocity_update pvvu_checker u_pvvu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(particle.valid),
	.in_ready(particle.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.in_band(result.in_band),
	.speed_clamped(result.speed_clamped),
	.new_vel_x(result.new_vel_x),
	.cfg_ready(cfg.ready)
);
